>>> hw/rtl/sot_pkg.sv
// shared types and constants for the shape overlap tester
`default_nettype none

package sot_pkg;

   localparam int unsigned KIND_BITS = 2;

   typedef enum logic [KIND_BITS-1:0] {
      TEST_RECT_RECT     = 2'd0,
      TEST_RECT_CIRCLE   = 2'd1,
      TEST_CIRCLE_CIRCLE = 2'd2
   } test_kind_type;

endpackage

`default_nettype wire

>>> hw/rtl/shape_overlap_test.sv
// top level of the 2d shape overlap tester
`default_nettype none

// Tests two shapes for touch or overlap: rectangle against rectangle, rectangle
// (shape a) against circle (shape b), or circle against circle, all coordinates
// signed fixed point of COORD_BITS bits. Every accepted transaction gives exactly
// one rsp_hit. The block takes one transaction per cycle while rsp_ready stays
// high, and a result passes through an input register, a register after the
// three parallel squarers (dx squared, dy squared, radius squared) and the
// result register. A corner test reduces to the nearest corner on each axis, so
// three squarers serve all tests. Back pressure on rsp_ready stalls the stages
// in order; empty stages still fill. req_type 3 gives no hit.
module shape_overlap_test #(
   parameter int unsigned COORD_BITS = 16
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_ready,
   input  wire logic [sot_pkg::KIND_BITS-1:0]        req_type,
   input  wire logic signed [COORD_BITS-1:0]         req_a_left_or_cx,
   input  wire logic signed [COORD_BITS-1:0]         req_a_top_or_cy,
   input  wire logic signed [COORD_BITS-1:0]         req_a_right_or_radius,
   input  wire logic signed [COORD_BITS-1:0]         req_a_bottom,
   input  wire logic signed [COORD_BITS-1:0]         req_b_left_or_cx,
   input  wire logic signed [COORD_BITS-1:0]         req_b_top_or_cy,
   input  wire logic signed [COORD_BITS-1:0]         req_b_right_or_radius,
   input  wire logic signed [COORD_BITS-1:0]         req_b_bottom,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_ready,
   output      logic                                 rsp_hit
);
   import sot_pkg::*;

   localparam int unsigned EXT_BITS = COORD_BITS + 2;
   localparam int unsigned SQ_BITS  = 2 * COORD_BITS;
   localparam int unsigned SUM_BITS = SQ_BITS + 1;

   // absolute difference of two coordinates, always fits COORD_BITS unsigned
   function automatic logic [COORD_BITS-1:0] abs_diff(input logic signed [COORD_BITS-1:0] p,
                                                      input logic signed [COORD_BITS-1:0] q);
      logic signed [COORD_BITS:0] d;
      logic signed [COORD_BITS:0] n;
      d = (COORD_BITS+1)'(p) - (COORD_BITS+1)'(q);
      n = -d;
      return d[COORD_BITS] ? n[COORD_BITS-1:0] : d[COORD_BITS-1:0];
   endfunction

   // stage ready chain
   logic s1_ready, s2_ready, s3_ready;

   // input register
   logic                           s1_valid_ff, s1_valid_in;
   logic [KIND_BITS-1:0]           s1_kind_ff;
   logic signed [COORD_BITS-1:0]   s1_a_ff [4];
   logic signed [COORD_BITS-1:0]   s1_b_ff [4];

   // squares register
   logic                           s2_valid_ff, s2_valid_in;
   logic [SQ_BITS-1:0]             s2_sq_x_ff, s2_sq_y_ff, s2_sq_r_ff;
   logic                           s2_use_sq_ff, s2_neg_ff, s2_direct_ff;

   // result register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic                           rsp_hit_ff;

   // first stage logic
   logic signed [EXT_BITS-1:0]     cx, cy, rad, left, top, right, bottom, rad_sum;
   logic                           rr_hit, in_span, grown_hit;
   logic [COORD_BITS-1:0]          dxl, dxr, dyt, dyb;
   logic [COORD_BITS-1:0]          op_x, op_y, op_r;
   logic                           use_sq, neg, direct;

   // second stage logic
   logic [SUM_BITS-1:0]            sq_sum;
   logic                           hit_in;

   assign s3_ready  = !rsp_valid_ff || rsp_ready;
   assign s2_ready  = !s2_valid_ff || s3_ready;
   assign s1_ready  = !s1_valid_ff || s2_ready;
   assign req_ready = s1_ready;

   always_comb begin
      s1_valid_in  = s1_ready ? req_valid : s1_valid_ff;
      s2_valid_in  = s2_ready ? s1_valid_ff : s2_valid_ff;
      rsp_valid_in = s3_ready ? s2_valid_ff : rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_kind_ff <= req_type;
         s1_a_ff[0] <= req_a_left_or_cx;
         s1_a_ff[1] <= req_a_top_or_cy;
         s1_a_ff[2] <= req_a_right_or_radius;
         s1_a_ff[3] <= req_a_bottom;
         s1_b_ff[0] <= req_b_left_or_cx;
         s1_b_ff[1] <= req_b_top_or_cy;
         s1_b_ff[2] <= req_b_right_or_radius;
         s1_b_ff[3] <= req_b_bottom;
      end
   end

   // rectangle against rectangle, inclusive edges
   assign rr_hit = !(s1_a_ff[0] > s1_b_ff[2]) && !(s1_a_ff[2] < s1_b_ff[0]) &&
                   !(s1_a_ff[1] > s1_b_ff[3]) && !(s1_a_ff[3] < s1_b_ff[1]);

   // rectangle a against circle b
   always_comb begin
      cx      = EXT_BITS'(s1_b_ff[0]);
      cy      = EXT_BITS'(s1_b_ff[1]);
      rad     = EXT_BITS'(s1_b_ff[2]);
      left    = EXT_BITS'(s1_a_ff[0]);
      top     = EXT_BITS'(s1_a_ff[1]);
      right   = EXT_BITS'(s1_a_ff[2]);
      bottom  = EXT_BITS'(s1_a_ff[3]);
      rad_sum = EXT_BITS'(s1_a_ff[2]) + EXT_BITS'(s1_b_ff[2]);
      in_span = (left <= cx && cx <= right) || (top <= cy && cy <= bottom);
      grown_hit = !(cx < left - rad) && !(cx > right + rad) &&
                  !(cy < top - rad) && !(cy > bottom + rad);
   end

   // nearest corner per axis
   assign dxl = abs_diff(s1_b_ff[0], s1_a_ff[0]);
   assign dxr = abs_diff(s1_b_ff[0], s1_a_ff[2]);
   assign dyt = abs_diff(s1_b_ff[1], s1_a_ff[1]);
   assign dyb = abs_diff(s1_b_ff[1], s1_a_ff[3]);

   always_comb begin
      op_x   = abs_diff(s1_a_ff[0], s1_b_ff[0]);
      op_y   = abs_diff(s1_a_ff[1], s1_b_ff[1]);
      op_r   = rad_sum[COORD_BITS-1:0];
      use_sq = 1'b0;
      neg    = 1'b0;
      direct = 1'b0;
      unique case (s1_kind_ff)
         TEST_RECT_RECT: begin
            direct = rr_hit;
         end
         TEST_RECT_CIRCLE: begin
            op_x   = (dxl < dxr) ? dxl : dxr;
            op_y   = (dyt < dyb) ? dyt : dyb;
            op_r   = s1_b_ff[2];
            neg    = s1_b_ff[2][COORD_BITS-1];
            use_sq = !in_span;
            direct = grown_hit;
         end
         TEST_CIRCLE_CIRCLE: begin
            neg    = rad_sum[EXT_BITS-1];
            use_sq = 1'b1;
         end
         default: begin
            direct = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_sq_x_ff   <= SQ_BITS'(op_x) * SQ_BITS'(op_x);
         s2_sq_y_ff   <= SQ_BITS'(op_y) * SQ_BITS'(op_y);
         s2_sq_r_ff   <= SQ_BITS'(op_r) * SQ_BITS'(op_r);
         s2_use_sq_ff <= use_sq;
         s2_neg_ff    <= neg;
         s2_direct_ff <= direct;
      end
   end

   // squared distance against squared radius
   always_comb begin
      sq_sum = SUM_BITS'(s2_sq_x_ff) + SUM_BITS'(s2_sq_y_ff);
      hit_in = s2_use_sq_ff ? (!s2_neg_ff && sq_sum <= SUM_BITS'(s2_sq_r_ff))
                            : s2_direct_ff;
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         rsp_hit_ff <= hit_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hit   = rsp_hit_ff;

endmodule

`default_nettype wire

>>> hw/rtl/sot_checker.sv
// port checker for the shape overlap tester, bound to the top level
`default_nettype none

module sot_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_hit
);

   // a stalled result transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hit))
      else $error("result changed while stalled");

   // reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a draining output lets the whole pipeline advance
   a_ready_flow: assert property (@(posedge clock) disable iff (reset)
      rsp_ready |-> req_ready)
      else $error("input stalled while output drains");

   // an idle pipeline takes a transaction
   a_idle_ready: assert property (@(posedge clock) disable iff (reset)
      !req_valid && !rsp_valid && $past(!req_valid) && $past(!req_valid, 2) &&
      $past(!req_valid, 3) && !$past(reset, 3) |-> req_ready)
      else $error("idle block not ready");

endmodule

bind shape_overlap_test sot_checker u_sot_checker (.*);

`default_nettype wire
